// File: rtl/hss_pkg.sv
// ----------------------------------------------------------------------------
// Hall six-step commutator package
// Shared widths, codes, lookup tables and small helper functions.
// ----------------------------------------------------------------------------
package hss_pkg;

	// field widths
	localparam int CODE_W  = 3;
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 16;
	localparam int PP_W    = 6;
	localparam int SPEED_W = 14;
	localparam int STEP_W  = 3;
	localparam int DRIVE_W = 2;
	localparam int DIR_W   = 2;
	localparam int SNUM_W  = 4;
	localparam int RSN_W   = 3;
	localparam int CIDX_W  = 2;

	// speed arithmetic: 60000 / (6 * dt) == 10000 / dt
	localparam int STEP_COUNT    = 6;
	localparam int RPM_NUMERATOR = 60000;
	localparam logic [SPEED_W-1:0] RPM_DIVIDEND = SPEED_W'(RPM_NUMERATOR / STEP_COUNT);

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_SETTLE  = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_STOP    = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_PERIOD  = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_POLES   = 2'd3;

	// configuration reset values
	localparam logic [CFG_W-1:0] SETTLE_RST = 16'd5;
	localparam logic [CFG_W-1:0] STOP_RST   = 16'd1000;
	localparam logic [CFG_W-1:0] PERIOD_RST = 16'd500;
	localparam logic [PP_W-1:0]  POLES_RST  = 6'd6;

	// report reasons
	localparam logic [RSN_W-1:0] R_NONE       = 3'd0;
	localparam logic [RSN_W-1:0] R_TRANSITION = 3'd1;
	localparam logic [RSN_W-1:0] R_INVALID    = 3'd2;
	localparam logic [RSN_W-1:0] R_STOPPED    = 3'd3;
	localparam logic [RSN_W-1:0] R_PERIODIC   = 3'd4;

	// rotation codes
	localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
	localparam logic [DIR_W-1:0] DIR_FWD  = 2'b01;
	localparam logic [DIR_W-1:0] DIR_REV  = 2'b11;

	// phase drive levels
	localparam logic [DRIVE_W-1:0] PH_FLOAT = 2'd0;
	localparam logic [DRIVE_W-1:0] PH_LOW   = 2'd1;
	localparam logic [DRIVE_W-1:0] PH_HIGH  = 2'd2;

	// "no code" marker for candidate and accepted code registers
	localparam logic [CODE_W:0] NO_CODE = 4'd8;

	typedef struct packed {
		logic              ok;
		logic [STEP_W-1:0] step;
	} hall_step_t;

	typedef struct packed {
		logic [DRIVE_W-1:0] a;
		logic [DRIVE_W-1:0] b;
		logic [DRIVE_W-1:0] c;
	} drive_t;

	// Hall code to commutation step; 000 and 111 are not valid
	function automatic hall_step_t step_of(input logic [CODE_W-1:0] code);
		hall_step_t r;
		r.ok = 1'b1;
		case (code)
			3'd1: r.step = 3'd0;
			3'd2: r.step = 3'd4;
			3'd3: r.step = 3'd5;
			3'd4: r.step = 3'd2;
			3'd5: r.step = 3'd1;
			3'd6: r.step = 3'd3;
			default: begin
				r.ok   = 1'b0;
				r.step = 3'd0;
			end
		endcase
		return r;
	endfunction

	// phase pattern per step
	function automatic drive_t drive_of(input logic [STEP_W-1:0] step);
		drive_t d;
		case (step)
			3'd0: d = '{PH_HIGH,  PH_LOW,   PH_FLOAT};
			3'd1: d = '{PH_HIGH,  PH_FLOAT, PH_LOW};
			3'd2: d = '{PH_FLOAT, PH_HIGH,  PH_LOW};
			3'd3: d = '{PH_LOW,   PH_HIGH,  PH_FLOAT};
			3'd4: d = '{PH_LOW,   PH_FLOAT, PH_HIGH};
			3'd5: d = '{PH_FLOAT, PH_LOW,   PH_HIGH};
			default: d = '{PH_HIGH, PH_LOW, PH_FLOAT};
		endcase
		return d;
	endfunction

	// direction from one known step to the next
	function automatic logic [DIR_W-1:0] rot_of(input logic [STEP_W-1:0] prev,
			input logic [STEP_W-1:0] next);
		logic [STEP_W-1:0] inc;
		logic [STEP_W-1:0] dec;
		inc = (prev == 3'd5) ? 3'd0 : prev + 3'd1;
		dec = (prev == 3'd0) ? 3'd5 : prev - 3'd1;
		if (next == inc)
			return DIR_FWD;
		else if (next == dec)
			return DIR_REV;
		else
			return DIR_NONE;
	endfunction

endpackage

// File: rtl/hss_div.sv
// ----------------------------------------------------------------------------
// Hall six-step commutator divider
// Restoring radix-2 divider, one quotient bit per cycle, shared by both
// speed divisions. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module hss_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [hss_pkg::SPEED_W-1:0] dividend,
	input  logic [hss_pkg::SPEED_W-1:0] divisor,
	output logic                        done,
	output logic [hss_pkg::SPEED_W-1:0] quotient
);
	import hss_pkg::*;

	localparam int CNT_W = $clog2(SPEED_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SPEED_W-1:0] quo_q;
	logic [SPEED_W-1:0] rem_q;
	logic [SPEED_W-1:0] dvs_q;
	logic [SPEED_W:0]   shifted;
	logic [SPEED_W+1:0] trial;

	// one trial subtraction
	assign shifted = {rem_q, quo_q[SPEED_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, dvs_q};

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SPEED_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[SPEED_W+1]) begin
				rem_q <= trial[SPEED_W-1:0];
				quo_q <= {quo_q[SPEED_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[SPEED_W-1:0];
				quo_q <= {quo_q[SPEED_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/hall_six_step_commutator.sv
// ----------------------------------------------------------------------------
// Hall six-step commutator
// Debounces Hall codes, sets the six-step phase drive and reports direction
// and electrical / mechanical speed with stop and periodic reports.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one item is one poll with the Hall
//    code and the millisecond time. in_stall is high while an item is in work.
//  - Output channel (out_valid / out_stall): exactly one result item per poll,
//    held in an output register until taken.
//  - Config channel (cfg_valid / cfg_ready): cfg_ready is always high; write
//    only while the block is idle.
//  - Sequence: an accepted item passes the evaluate, stop, periodic and
//    output states; a transition that needs both speed divisions runs them
//    back to back on one shared 14-bit divider, one quotient bit per cycle,
//    between evaluate and stop.
//  - Flow: no new item is taken until the result of the last one is loaded
//    into the output register; the next item is taken the cycle after the
//    result is loaded, even if the receiver stalls it.
//  - When the receiver stalls with a result still held, a finished item waits
//    in the last sequencer state and no new item is taken.
//  - Reset: telemetry state, configuration and out_valid go to their reset
//    values, no code accepted, drive step set to the first pattern.
// ----------------------------------------------------------------------------
module hall_six_step_commutator (
	input  logic                                clk,
	input  logic                                arst_n,
	// poll input
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [hss_pkg::CODE_W-1:0]          hall_code,
	input  logic [hss_pkg::TIME_W-1:0]          time_ms,
	// result output
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [hss_pkg::DRIVE_W-1:0]         drive_a,
	output logic [hss_pkg::DRIVE_W-1:0]         drive_b,
	output logic [hss_pkg::DRIVE_W-1:0]         drive_c,
	output logic signed [hss_pkg::SNUM_W-1:0]   step_number,
	output logic signed [hss_pkg::DIR_W-1:0]    rotation,
	output logic [hss_pkg::SPEED_W-1:0]         electrical_speed,
	output logic [hss_pkg::SPEED_W-1:0]         mechanical_speed,
	output logic                                code_valid,
	output logic [hss_pkg::CODE_W-1:0]          reported_code,
	output logic [hss_pkg::RSN_W-1:0]           report_reason,
	// configuration
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [hss_pkg::CIDX_W-1:0]          cfg_index,
	input  logic [hss_pkg::CFG_W-1:0]           cfg_data
);
	import hss_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_EVAL   = 7'b0000010,
		S_DIV_E  = 7'b0000100,
		S_DIV_M  = 7'b0001000,
		S_STOP   = 7'b0010000,
		S_PERIOD = 7'b0100000,
		S_OUT    = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [CFG_W-1:0] settle_q;
	logic [CFG_W-1:0] stop_q;
	logic [CFG_W-1:0] period_q;
	logic [PP_W-1:0]  poles_q;

	// captured poll
	logic [CODE_W-1:0] code_q;
	logic [TIME_W-1:0] now_q;

	// telemetry state
	logic [CODE_W:0]    cand_code_q;
	logic [TIME_W-1:0]  cand_time_q;
	logic [CODE_W:0]    acc_code_q;
	logic [STEP_W-1:0]  cur_step_q;
	logic               step_known_q;
	logic [STEP_W-1:0]  drive_step_q;
	logic [DIR_W-1:0]   dir_q;
	logic [SPEED_W-1:0] elec_q;
	logic [SPEED_W-1:0] mech_q;
	logic [TIME_W-1:0]  trans_time_q;
	logic [TIME_W-1:0]  last_rep_q;
	logic [RSN_W-1:0]   reason_q;

	// output register
	logic               out_valid_q;
	drive_t             out_drive_q;
	logic [SNUM_W-1:0]  out_step_q;
	logic [DIR_W-1:0]   out_dir_q;
	logic [SPEED_W-1:0] out_elec_q;
	logic [SPEED_W-1:0] out_mech_q;
	logic               out_cvalid_q;
	logic [CODE_W-1:0]  out_code_q;
	logic [RSN_W-1:0]   out_reason_q;

	// evaluation terms
	logic [TIME_W-1:0]  since_cand;
	logic [TIME_W-1:0]  since_trans;
	logic [TIME_W-1:0]  since_rep;
	logic               cand_match;
	logic               accept;
	hall_step_t         hs;
	logic               same_step;
	logic               too_slow;
	logic               need_div;
	logic               stop_hit;
	logic               period_hit;
	logic               out_load;
	logic [PP_W-1:0]    poles_eff;

	// divider hookup
	logic               div_start;
	logic [SPEED_W-1:0] div_dividend;
	logic [SPEED_W-1:0] div_divisor;
	logic               div_done;
	logic [SPEED_W-1:0] div_quotient;

	hss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// elapsed times, all modulo 2^32
	assign since_cand  = now_q - cand_time_q;
	assign since_trans = now_q - trans_time_q;
	assign since_rep   = now_q - last_rep_q;

	// debounce and acceptance
	assign hs         = step_of(code_q);
	assign cand_match = ({1'b0, code_q} == cand_code_q);
	assign accept     = cand_match && ({1'b0, code_q} != acc_code_q) &&
	                    (since_cand >= {16'b0, settle_q});
	assign same_step  = step_known_q && (cur_step_q == hs.step);
	assign too_slow   = since_trans > {18'b0, RPM_DIVIDEND};
	assign need_div   = step_known_q && (since_trans != '0) && !too_slow;
	assign poles_eff  = (poles_q == '0) ? PP_W'(1) : poles_q;

	// stop and periodic checks
	assign stop_hit   = step_known_q && (mech_q != '0) && (since_trans >= {16'b0, stop_q});
	assign period_hit = since_rep >= {16'b0, period_q};

	// divider operands: electrical first, then mechanical
	always_comb begin
		div_start    = 1'b0;
		div_dividend = RPM_DIVIDEND;
		div_divisor  = since_trans[SPEED_W-1:0];
		case (state_q)
			S_EVAL: begin
				div_start = accept && hs.ok && !same_step && need_div;
			end
			S_DIV_E: begin
				div_start    = div_done;
				div_dividend = div_quotient;
				div_divisor  = {{(SPEED_W-PP_W){1'b0}}, poles_eff};
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_RST;
			stop_q   <= STOP_RST;
			period_q <= PERIOD_RST;
			poles_q  <= POLES_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SETTLE: settle_q <= cfg_data;
				CFG_STOP:   stop_q   <= cfg_data;
				CFG_PERIOD: period_q <= cfg_data;
				CFG_POLES:  poles_q  <= cfg_data[PP_W-1:0];
				default:    settle_q <= settle_q;
			endcase
		end
	end

	// captured poll
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			code_q <= hall_code;
			now_q  <= time_ms;
		end
	end

	// sequencer and telemetry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cand_code_q  <= NO_CODE;
			cand_time_q  <= '0;
			acc_code_q   <= NO_CODE;
			cur_step_q   <= '0;
			step_known_q <= 1'b0;
			drive_step_q <= '0;
			dir_q        <= DIR_NONE;
			elec_q       <= '0;
			mech_q       <= '0;
			trans_time_q <= '0;
			last_rep_q   <= '0;
			reason_q     <= R_NONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						reason_q <= R_NONE;
						state_q  <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= S_STOP;
					if (!cand_match) begin
						cand_code_q <= {1'b0, code_q};
						cand_time_q <= now_q;
					end else if (accept) begin
						if (!hs.ok) begin
							acc_code_q   <= {1'b0, code_q};
							step_known_q <= 1'b0;
							dir_q        <= DIR_NONE;
							elec_q       <= '0;
							mech_q       <= '0;
							reason_q     <= R_INVALID;
							last_rep_q   <= now_q;
						end else begin
							drive_step_q <= hs.step;
							if (!same_step) begin
								dir_q <= step_known_q ? rot_of(cur_step_q, hs.step) : DIR_NONE;
								if (step_known_q && too_slow) begin
									elec_q <= '0;
									mech_q <= '0;
								end
								if (div_start)
									state_q <= S_DIV_E;
								acc_code_q   <= {1'b0, code_q};
								cur_step_q   <= hs.step;
								trans_time_q <= now_q;
								step_known_q <= 1'b1;
								reason_q     <= R_TRANSITION;
								last_rep_q   <= now_q;
							end
						end
					end
				end
				S_DIV_E: begin
					if (div_done) begin
						elec_q  <= div_quotient;
						state_q <= S_DIV_M;
					end
				end
				S_DIV_M: begin
					if (div_done) begin
						mech_q  <= div_quotient;
						state_q <= S_STOP;
					end
				end
				S_STOP: begin
					if (stop_hit) begin
						elec_q     <= '0;
						mech_q     <= '0;
						dir_q      <= DIR_NONE;
						reason_q   <= R_STOPPED;
						last_rep_q <= now_q;
					end
					state_q <= S_PERIOD;
				end
				S_PERIOD: begin
					if (period_hit) begin
						reason_q   <= R_PERIODIC;
						last_rep_q <= now_q;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_drive_q  <= drive_of(drive_step_q);
			out_step_q   <= step_known_q ? {1'b0, cur_step_q} : {SNUM_W{1'b1}};
			out_dir_q    <= dir_q;
			out_elec_q   <= elec_q;
			out_mech_q   <= mech_q;
			out_cvalid_q <= step_known_q;
			out_code_q   <= acc_code_q[CODE_W] ? '0 : acc_code_q[CODE_W-1:0];
			out_reason_q <= reason_q;
		end
	end

	assign in_stall         = (state_q != S_IDLE);
	assign cfg_ready        = 1'b1;
	assign out_valid        = out_valid_q;
	assign drive_a          = out_drive_q.a;
	assign drive_b          = out_drive_q.b;
	assign drive_c          = out_drive_q.c;
	assign step_number      = out_step_q;
	assign rotation         = out_dir_q;
	assign electrical_speed = out_elec_q;
	assign mechanical_speed = out_mech_q;
	assign code_valid       = out_cvalid_q;
	assign reported_code    = out_code_q;
	assign report_reason    = out_reason_q;

	// checks
	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV_E || state_q == S_DIV_M))
		else $error("divider finished outside a division state");

	a_mech_le_elec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_DIV_M) |-> (mech_q <= elec_q))
		else $error("mechanical speed above electrical speed");

	a_unknown_no_dir: assert property (@(posedge clk) disable iff (!arst_n)
		!step_known_q |-> (dir_q == DIR_NONE))
		else $error("direction set without a known step");

	a_load_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result shown without finishing an item");

endmodule
